// File: src/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types, coefficients and helpers of the lux conversion core.
// ----------------------------------------------------------------------------
package lcp_pkg;

  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_UPPER,
    BAND_HIGH
  } band_t;

  typedef enum logic {
    REG_HIGH_GAIN,
    REG_INTEGRATION_MS
  } reg_idx_t;

  // kill: result is forced to zero lux (saturated, dark or ratio too high)
  typedef struct packed {
    logic [15:0] ch0;
    logic [15:0] ch1;
    band_t       band;
    logic        kill;
    logic        ok;
  } item_t;

  localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
  localparam int          QUEUE_DEPTH = 4;

  // band coefficients in units of 1e-5
  localparam logic [11:0] COEF_LOW_A   = 12'd3040;
  localparam logic [12:0] COEF_LOW_B   = 13'd6200;
  localparam logic [11:0] COEF_MID_A   = 12'd2240;
  localparam logic [11:0] COEF_MID_B   = 12'd3100;
  localparam logic [11:0] COEF_UPPER_A = 12'd1280;
  localparam logic [11:0] COEF_UPPER_B = 12'd1530;
  localparam logic [11:0] COEF_HIGH_A  = 12'd146;
  localparam logic [11:0] COEF_HIGH_B  = 12'd112;

  localparam logic [12:0] SCALE_GAIN_HI = 13'd402;
  localparam logic [12:0] SCALE_GAIN_LO = 13'd6432;
  localparam logic [16:0] MS_UNIT       = 17'd100000;
  localparam logic [15:0] MS_RESET      = 16'd402;

  localparam int TAB_W   = 24;  // r^1.4 in Q24
  localparam int DIFF_W  = 28;
  localparam int M1_W    = 41;
  localparam int VAL_W   = 57;
  localparam int NUM_W   = 58;
  localparam int LUXQ_W  = 42;
  localparam int LUX_W   = 40;

  // largest s < 4096 with s^5 <= t
  function automatic logic [63:0] fifth_root(input logic [63:0] t);
    logic [63:0] s;
    logic [63:0] c;
    s = '0;
    for (int b = 11; b >= 0; b--) begin
      c = s | (64'd1 << b);
      if (c * c * c * c * c <= t) s = c;
    end
    return s;
  endfunction

endpackage

// File: src/light_sensor_lux_conversion_core.sv
// ----------------------------------------------------------------------------
// light_sensor_lux_conversion_core
// Two-channel light count to lux converter with APB-style register port.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall    in_ch0_count, in_ch1_count
//   out_      output     out_valid / out_stall  out_lux_fixed, out_result_ok
//   config    input      psel/penable/pready    paddr, pwdata, prdata
//
// One pair per cycle while the output is not stalled; a pair passes the
// queue, log2(N) + 16 ratio divider stages, five math stages, 42 normalize
// divider stages and the output register.
// Reset is synchronous; no clearing pass is needed.
// out_stall freezes the whole pipeline while out_valid is high; the 4-entry
// front queue keeps taking pairs until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module light_sensor_lux_conversion_core #(
  parameter int LUX_FRACTION_BITS   = 8,
  parameter int POWER_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_ch0_count,
  input  logic [15:0] in_ch1_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [39:0] out_lux_fixed,
  output logic        out_result_ok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEN_W = 49 - LUX_FRACTION_BITS;

  logic              high_gain_r;
  logic [15:0]       ms_r;
  logic [12:0]       scale_r;
  logic [DEN_W-1:0]  den_r;
  logic [15:0]       ms_eff;
  logic [32:0]       ms_prod;
  logic              wr_en;
  lcp_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = lcp_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_gain_r <= 1'b0;
      ms_r        <= lcp_pkg::MS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        lcp_pkg::REG_HIGH_GAIN:      high_gain_r <= pwdata[0];
        lcp_pkg::REG_INTEGRATION_MS: ms_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lcp_pkg::REG_HIGH_GAIN:      prdata = {31'd0, high_gain_r};
      lcp_pkg::REG_INTEGRATION_MS: prdata = {16'd0, ms_r};
      default:                     prdata = '0;
    endcase
  end

  // zero integration time behaves as 1 ms
  assign ms_eff  = (ms_r == 16'd0) ? 16'd1 : ms_r;
  assign ms_prod = 33'(lcp_pkg::MS_UNIT) * 33'(ms_eff);

  always_ff @(posedge clk) begin
    scale_r <= high_gain_r ? lcp_pkg::SCALE_GAIN_HI : lcp_pkg::SCALE_GAIN_LO;
    den_r   <= DEN_W'(ms_prod) << (16 - LUX_FRACTION_BITS);
  end

  logic           push;
  logic           pop;
  logic           q_full;
  logic           head_vld;
  lcp_pkg::item_t push_item;
  lcp_pkg::item_t head_item;

  lcp_front u_front (
    .in_valid     (in_valid),
    .in_ch0_count (in_ch0_count),
    .in_ch1_count (in_ch1_count),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .push         (push),
    .item         (push_item)
  );

  lcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .head_vld  (head_vld),
    .head_item (head_item)
  );

  lcp_back #(
    .LUX_FRACTION_BITS   (LUX_FRACTION_BITS),
    .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_vld         (head_vld),
    .q_item        (head_item),
    .q_pop         (pop),
    .scale         (scale_r),
    .den           (den_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_lux_fixed (out_lux_fixed),
    .out_result_ok (out_result_ok)
  );

endmodule

// File: src/lcp_front.sv
// ----------------------------------------------------------------------------
// lcp_front
// Accepts count pairs and classifies them into ratio bands.
// ----------------------------------------------------------------------------
module lcp_front (
  input  logic                 in_valid,
  input  logic [15:0]          in_ch0_count,
  input  logic [15:0]          in_ch1_count,
  input  logic                 q_full,
  output logic                 in_stall,
  output logic                 push,
  output lcp_pkg::item_t       item
);

  logic        sat;
  logic        lt_half;
  logic        lt_61;
  logic        lt_80;
  logic        lt_130;
  logic [22:0] m100_ch1;
  logic [22:0] m61_ch0;

  assign sat      = (in_ch0_count == lcp_pkg::COUNT_SAT) || (in_ch1_count == lcp_pkg::COUNT_SAT);
  assign lt_half  = {in_ch1_count, 1'b0} < {1'b0, in_ch0_count};
  assign m100_ch1 = 23'(in_ch1_count) * 23'd100;
  assign m61_ch0  = 23'(in_ch0_count) * 23'd61;
  assign lt_61    = m100_ch1 < m61_ch0;
  assign lt_80    = (19'(in_ch1_count) * 19'd5) < (19'(in_ch0_count) * 19'd4);
  assign lt_130   = (20'(in_ch1_count) * 20'd10) < (20'(in_ch0_count) * 20'd13);

  always_comb begin
    item.ch0  = in_ch0_count;
    item.ch1  = in_ch1_count;
    item.ok   = !sat;
    item.kill = sat || (in_ch0_count == 16'd0) || !lt_130;
    if (lt_half) begin
      item.band = lcp_pkg::BAND_LOW;
    end else if (lt_61) begin
      item.band = lcp_pkg::BAND_MID;
    end else if (lt_80) begin
      item.band = lcp_pkg::BAND_UPPER;
    end else begin
      item.band = lcp_pkg::BAND_HIGH;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

// File: src/lcp_queue.sv
// ----------------------------------------------------------------------------
// lcp_queue
// Short FIFO between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module lcp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcp_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           head_vld,
  output lcp_pkg::item_t head_item
);

  localparam int DEPTH = lcp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcp_pkg::item_t   data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign head_vld  = (count_r != '0);
  assign head_item = data_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && head_vld)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && head_vld) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && head_vld) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) data_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: src/lcp_div_pipe.sv
// ----------------------------------------------------------------------------
// lcp_div_pipe
// Pipelined restoring divider, one quotient bit per stage, side payload.
// ----------------------------------------------------------------------------
module lcp_div_pipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int QUO_W = 16,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_vld,
  output logic [QUO_W-1:0] out_quo,
  output logic [PAY_W-1:0] out_pay
);

  logic             vld_r [QUO_W];
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [PAY_W-1:0] pay_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic             vld_i;
    logic [NUM_W-1:0] rem_i;
    logic [DEN_W-1:0] den_i;
    logic [QUO_W-1:0] quo_i;
    logic [PAY_W-1:0] pay_i;
    logic [NUM_W-1:0] den_x;
    logic             take;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = in_num;
      assign den_i = in_den;
      assign quo_i = '0;
      assign pay_i = in_pay;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign den_i = den_r[k-1];
      assign quo_i = quo_r[k-1];
      assign pay_i = pay_r[k-1];
    end

    assign den_x = NUM_W'(den_i);
    assign take  = (rem_i >> B) >= den_x;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? (rem_i - (den_x << B)) : rem_i;
        den_r[k] <= den_i;
        quo_r[k] <= quo_i | (take ? (QUO_W'(1) << B) : '0);
        pay_r[k] <= pay_i;
      end
    end
  end

  assign out_vld = vld_r[QUO_W-1];
  assign out_quo = quo_r[QUO_W-1];
  assign out_pay = pay_r[QUO_W-1];

endmodule

// File: src/lcp_back.sv
// ----------------------------------------------------------------------------
// lcp_back
// Arithmetic pipeline: ratio divide, r^1.4 lookup, band formula, normalize.
// ----------------------------------------------------------------------------
module lcp_back #(
  parameter int LUX_FRACTION_BITS   = 8,
  parameter int POWER_TABLE_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_vld,
  input  lcp_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic [12:0]                 scale,
  input  logic [48-LUX_FRACTION_BITS:0] den,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lcp_pkg::LUX_W-1:0]   out_lux_fixed,
  output logic                        out_result_ok
);

  localparam int N         = POWER_TABLE_ENTRIES;
  localparam int IDX_W     = $clog2(N);
  localparam int TIDX_W    = $clog2(N + 1);
  localparam int POS_W     = IDX_W + 16;
  localparam int TWO_N_W   = $clog2(2 * N + 1);
  localparam int RNUM_W    = 32 + TWO_N_W;
  localparam int DEN_W     = 49 - LUX_FRACTION_BITS;
  localparam int ITEM_W    = $bits(lcp_pkg::item_t);
  localparam int TAB_W     = lcp_pkg::TAB_W;
  localparam int DIFF_W    = lcp_pkg::DIFF_W;
  localparam int M1_W      = lcp_pkg::M1_W;
  localparam int VAL_W     = lcp_pkg::VAL_W;
  localparam int NUM_W     = lcp_pkg::NUM_W;
  localparam int LUXQ_W    = lcp_pkg::LUXQ_W;
  localparam int LUX_W     = lcp_pkg::LUX_W;
  localparam logic [37:0] LOW_BASE = 38'(lcp_pkg::COEF_LOW_A) << 24;

  logic en;
  logic out_valid_r;
  logic [LUX_W-1:0] lux_r;
  logic ok_r;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_vld;

  // r^1.4 table, Q24, at r = i/(2N)
  logic [TAB_W-1:0] pow_tab [N+1];
  for (genvar i = 0; i <= N; i++) begin : g_tab
    localparam logic [63:0] SQ   = ((64'(i) * 64'(i)) << 38) / (64'd4 * 64'(N) * 64'(N));
    localparam logic [63:0] ROOT = lcp_pkg::fifth_root(SQ << 22);
    localparam logic [63:0] ENT  = ((64'(i) * ROOT) << 12) / (64'd2 * 64'(N));
    assign pow_tab[i] = TAB_W'(ENT);
  end

  // ratio divider, numerator is zero except for unkilled lowest band items
  logic [RNUM_W-1:0] rnum;
  logic              r_vld;
  logic [POS_W-1:0]  r_pos;
  logic [ITEM_W-1:0] r_pay;
  lcp_pkg::item_t    r_item;

  assign rnum = (q_item.band == lcp_pkg::BAND_LOW && !q_item.kill) ?
                ((RNUM_W'(q_item.ch1) * RNUM_W'(2 * N)) << 16) : '0;

  lcp_div_pipe #(
    .NUM_W (RNUM_W),
    .DEN_W (16),
    .QUO_W (POS_W),
    .PAY_W (ITEM_W)
  ) u_ratio_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (q_pop),
    .in_num  (rnum),
    .in_den  (q_item.ch0),
    .in_pay  (ITEM_W'(q_item)),
    .out_vld (r_vld),
    .out_quo (r_pos),
    .out_pay (r_pay)
  );

  assign r_item = lcp_pkg::item_t'(r_pay);

  // stage A: table read, linear band difference
  logic [TIDX_W-1:0] idx_lo;
  logic [TIDX_W-1:0] idx_hi;
  logic [11:0]       coef_a;
  logic [11:0]       coef_b;
  logic [DIFF_W:0]   diff_full;

  assign idx_lo = TIDX_W'(r_pos[POS_W-1:16]);
  assign idx_hi = idx_lo + TIDX_W'(1);

  always_comb begin
    case (r_item.band)
      lcp_pkg::BAND_MID: begin
        coef_a = lcp_pkg::COEF_MID_A;
        coef_b = lcp_pkg::COEF_MID_B;
      end
      lcp_pkg::BAND_UPPER: begin
        coef_a = lcp_pkg::COEF_UPPER_A;
        coef_b = lcp_pkg::COEF_UPPER_B;
      end
      lcp_pkg::BAND_HIGH: begin
        coef_a = lcp_pkg::COEF_HIGH_A;
        coef_b = lcp_pkg::COEF_HIGH_B;
      end
      default: begin
        coef_a = '0;
        coef_b = '0;
      end
    endcase
  end

  assign diff_full = (29'(r_item.ch0) * 29'(coef_a)) - (29'(r_item.ch1) * 29'(coef_b));

  logic              a_vld_r;
  logic [TAB_W-1:0]  a_lo_r;
  logic [TAB_W-1:0]  a_hi_r;
  logic [15:0]       a_f_r;
  logic [DIFF_W-1:0] a_diff_r;
  lcp_pkg::item_t    a_item_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo_r   <= pow_tab[idx_lo];
      a_hi_r   <= pow_tab[idx_hi];
      a_f_r    <= r_pos[15:0];
      a_diff_r <= diff_full[DIFF_W-1:0];
      a_item_r <= r_item;
    end
  end

  // stage B: interpolation product, count or band difference times gain scale
  logic [TAB_W-1:0]  span;
  logic [DIFF_W-1:0] mop;
  logic              b_vld_r;
  logic [39:0]       b_prod_r;
  logic [TAB_W-1:0]  b_lo_r;
  logic [M1_W-1:0]   b_m1_r;
  lcp_pkg::item_t    b_item_r;

  assign span = (a_hi_r >= a_lo_r) ? (a_hi_r - a_lo_r) : '0;
  assign mop  = (a_item_r.band == lcp_pkg::BAND_LOW) ? DIFF_W'(a_item_r.ch0) : a_diff_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod_r <= 40'(span) * 40'(a_f_r);
      b_lo_r   <= a_lo_r;
      b_m1_r   <= M1_W'(mop) * M1_W'(scale);
      b_item_r <= a_item_r;
    end
  end

  // stage C: p = r^1.4, times 0.062
  logic [24:0]     p_sum;
  logic            c_vld_r;
  logic [37:0]     c_sub_r;
  logic [M1_W-1:0] c_m1_r;
  lcp_pkg::item_t  c_item_r;

  assign p_sum = 25'(b_lo_r) + 25'(b_prod_r[39:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      c_sub_r  <= 38'(p_sum) * 38'(lcp_pkg::COEF_LOW_B);
      c_m1_r   <= b_m1_r;
      c_item_r <= b_item_r;
    end
  end

  // stage D: band value
  logic [37:0]      c_low;
  logic [27:0]      c8;
  logic             d_vld_r;
  logic [VAL_W-1:0] d_val_r;
  logic             d_ok_r;

  assign c_low = (c_sub_r < LOW_BASE) ? (LOW_BASE - c_sub_r) : '0;
  assign c8    = c_low[35:8];

  always_ff @(posedge clk) begin
    if (en) begin
      d_ok_r <= c_item_r.ok;
      if (c_item_r.kill) begin
        d_val_r <= '0;
      end else if (c_item_r.band == lcp_pkg::BAND_LOW) begin
        d_val_r <= VAL_W'(c_m1_r[28:0]) * VAL_W'(c8);
      end else begin
        d_val_r <= VAL_W'(c_m1_r) << 16;
      end
    end
  end

  // stage E: add half divisor for round to nearest
  logic             e_vld_r;
  logic [NUM_W-1:0] e_num_r;
  logic             e_ok_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_num_r <= NUM_W'(d_val_r) + NUM_W'(den >> 1);
      e_ok_r  <= d_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= r_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  logic              x_vld;
  logic [LUXQ_W-1:0] x_quo;
  logic              x_ok;

  lcp_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (LUXQ_W),
    .PAY_W (1)
  ) u_lux_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (e_vld_r),
    .in_num  (e_num_r),
    .in_den  (den),
    .in_pay  (e_ok_r),
    .out_vld (x_vld),
    .out_quo (x_quo),
    .out_pay (x_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lux_r <= (|x_quo[LUXQ_W-1:LUX_W]) ? '1 : x_quo[LUX_W-1:0];
      ok_r  <= x_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lux_fixed = lux_r;
  assign out_result_ok = ok_r;

endmodule

// File: src/lcp_checker.sv
// ----------------------------------------------------------------------------
// lcp_checker
// Port-level assertions for the lux conversion core.
// ----------------------------------------------------------------------------
module lcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] out_lux_fixed,
  input logic        out_result_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_lux_fixed) && $stable(out_result_ok))
    else $error("stalled result changed");

  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_ok |-> out_lux_fixed == 40'd0)
    else $error("saturated transfer carries nonzero lux");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind light_sensor_lux_conversion_core lcp_checker u_lcp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_lux_fixed (out_lux_fixed),
  .out_result_ok (out_result_ok)
);
